>>> hdl/ssmc_pkg.sv
// Shared types and constants for the subarray sum match counter.
package ssmc_pkg;

    localparam int SSMC_TABLE_ENTRIES = 256;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               last;
    } t_in;

    typedef struct packed {
        logic [31:0] match_count;
        logic        table_full;
        logic        final_res;
    } t_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_PREP,
        ST_SCAN,
        ST_UPDATE,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic sum;
        logic prep;
        logic scan;
        logic update;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } t_stat;

endpackage

>>> hdl/ssmc_ctrl.sv
// Control state machine: sequences accept, sum, prep, table scan, update and result.
module ssmc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  ssmc_pkg::t_stat i_stat,
    output ssmc_pkg::t_cmd  o_cmd
);
    import ssmc_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SUM;
                end
            end
            ST_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = ST_PREP;
            end
            ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = ST_SCAN;
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = ST_OUT;
            end
            ST_OUT: begin
                // hold until the output register can take the result
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/ssmc_dp.sv
// Datapath: running sum, prefix-sum frequency table, match count, output register.
module ssmc_dp #(
    parameter int TABLE_ENTRIES = ssmc_pkg::SSMC_TABLE_ENTRIES
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [31:0]     i_cfg_data,
    input  ssmc_pkg::t_in   i_in_data,
    input  ssmc_pkg::t_cmd  i_cmd,
    output ssmc_pkg::t_stat o_stat,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output ssmc_pkg::t_out  o_out_data
);
    import ssmc_pkg::*;

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CW-1:0] FILL_MAX = CW'(TABLE_ENTRIES);

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    // frequency table; used entries always form the prefix below r_fill
    logic [31:0] mem_key  [TABLE_ENTRIES];
    logic [31:0] mem_freq [TABLE_ENTRIES];

    logic [31:0]   r_target;
    logic [15:0]   r_sample;
    logic          r_last;
    logic [31:0]   r_sum;
    logic [31:0]   r_pt;
    logic          r_full;
    logic [CW-1:0] r_fill;
    logic [CW-1:0] r_addr;
    logic          r_rd_pend;
    logic [IW-1:0] r_rd_idx;
    logic [31:0]   r_rd_key;
    logic [31:0]   r_rd_freq;
    logic [31:0]   r_want;
    logic          r_want_hit;
    logic [31:0]   r_want_freq;
    logic          r_sum_hit;
    logic [IW-1:0] r_sum_idx;
    logic [31:0]   r_sum_freq;
    logic          r_out_valid;
    t_out          r_out;

    logic          rd_en;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [31:0]   wr_freq;
    logic          has_room;

    assign has_room = (r_fill < FILL_MAX);
    assign rd_en    = i_cmd.scan && (r_addr < r_fill);
    assign wr_en    = i_cmd.update && (r_sum_hit || has_room);
    assign wr_addr  = r_sum_hit ? r_sum_idx : r_fill[IW-1:0];
    assign wr_freq  = r_sum_hit ? sat_add(r_sum_freq, 32'd1) : 32'd1;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_key[wr_addr]  <= r_sum;
            mem_freq[wr_addr] <= wr_freq;
        end
        if (rd_en) begin
            r_rd_key  <= mem_key[r_addr[IW-1:0]];
            r_rd_freq <= mem_freq[r_addr[IW-1:0]];
            r_rd_idx  <= r_addr[IW-1:0];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sample <= i_in_data.sample;
            r_last   <= i_in_data.last;
        end
        if (i_cmd.prep) begin
            r_want <= r_sum - r_target;
        end
        if (i_cmd.scan && r_rd_pend) begin
            if (r_rd_key == r_want) begin
                r_want_freq <= r_rd_freq;
            end
            if (r_rd_key == r_sum) begin
                r_sum_idx  <= r_rd_idx;
                r_sum_freq <= r_rd_freq;
            end
        end
        if (i_cmd.finish) begin
            r_out.match_count <= r_pt;
            r_out.table_full  <= r_full;
            r_out.final_res   <= r_last;
        end
    end

    // control and running state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target    <= '0;
            r_sum       <= '0;
            r_pt        <= '0;
            r_full      <= 1'b0;
            r_fill      <= '0;
            r_addr      <= '0;
            r_rd_pend   <= 1'b0;
            r_want_hit  <= 1'b0;
            r_sum_hit   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_target <= i_cfg_data;
            end
            if (i_cmd.sum) begin
                r_sum <= r_sum + {{16{r_sample[15]}}, r_sample};
            end
            if (i_cmd.prep) begin
                r_addr     <= '0;
                r_rd_pend  <= 1'b0;
                r_want_hit <= 1'b0;
                r_sum_hit  <= 1'b0;
                if (r_sum == r_target) begin
                    r_pt <= sat_add(r_pt, 32'd1);
                end
            end
            if (i_cmd.scan) begin
                r_rd_pend <= rd_en;
                if (rd_en) begin
                    r_addr <= r_addr + CW'(1);
                end
                if (r_rd_pend && (r_rd_key == r_want)) begin
                    r_want_hit <= 1'b1;
                end
                if (r_rd_pend && (r_rd_key == r_sum)) begin
                    r_sum_hit <= 1'b1;
                end
            end
            if (i_cmd.update) begin
                if (r_want_hit) begin
                    r_pt <= sat_add(r_pt, r_want_freq);
                end
                if (!r_sum_hit) begin
                    if (has_room) begin
                        r_fill <= r_fill + CW'(1);
                    end else begin
                        r_full <= 1'b1;
                    end
                end
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
                // drop all array state after the final element
                if (r_last) begin
                    r_sum  <= '0;
                    r_pt   <= '0;
                    r_full <= 1'b0;
                    r_fill <= '0;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.scan_done = (r_addr == r_fill) && !r_rd_pend;
    assign o_stat.out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid      = r_out_valid;
    assign o_out_data       = r_out;

endmodule

>>> hdl/subarray_sum_match_counter.sv
// Subarray sum match counter: prefix-sum table search with one result per sample.
// Each item is summed, scanned against every table entry in use and applied to the table,
// and its result handed to the output register, before the next item is accepted.
// The next item is taken while the previous result waits in the output register.
// Reset (synchronous, active low) clears sum, count, full flag, fill count and target.
// The table needs no clearing pass: the fill count marks which entries are live.
module subarray_sum_match_counter #(
    parameter int TABLE_ENTRIES = ssmc_pkg::SSMC_TABLE_ENTRIES
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [31:0]    i_cfg_data,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  ssmc_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output ssmc_pkg::t_out o_out_data
);
    import ssmc_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    ssmc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ssmc_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
